// ----- hdl/ctli_pkg.sv -----
// shared types and constants for the curve table linear interpolator
// no dependencies

package ctli_pkg;

    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 12;
    localparam int TS_W       = 18;
    localparam int COL_W      = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_MAX_W = 16;
    localparam int FRAC_W     = 16;
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int POS_W      = ALPHA_W + CFG_W;
    localparam int PROD_W     = DATA_W + 1 + ALPHA_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM   = 2'd1;

    localparam logic [CFG_W-1:0] GRID_MIN       = 7'd2;
    localparam logic [CFG_W-1:0] EMBED_MIN      = 7'd1;
    localparam logic [CFG_W-1:0] GRID_RESET     = 7'd2;
    localparam logic [CFG_W-1:0] EMBED_RESET    = 7'd64;
    localparam logic [ALPHA_W-1:0] ONE_Q16      = 17'h10000;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef struct packed {
        logic [CFG_W-1:0] grid;
        logic [CFG_W-1:0] embed;
    } t_geom;

    typedef struct packed {
        t_action               action;
        logic [ADDR_MAX_W-1:0] addr_a;
        logic [ADDR_MAX_W-1:0] addr_b;
        logic [DATA_W-1:0]     wdata;
        logic [ALPHA_W-1:0]    alpha;
    } t_cmd;

endpackage

// ----- hdl/ctli_in_if.sv -----
// input channel: table writes and timestep queries
// depends on ctli_pkg

interface ctli_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [ctli_pkg::INDEX_W-1:0]        table_index;
    logic signed [ctli_pkg::DATA_W-1:0]  table_value;
    logic signed [ctli_pkg::TS_W-1:0]    timestep;

    modport source (output valid, action, table_index, table_value, timestep, input ready);
    modport sink (input valid, action, table_index, table_value, timestep, output ready);
endinterface

// ----- hdl/ctli_out_if.sv -----
// output channel: interpolated words, one item per column
// depends on ctli_pkg

interface ctli_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctli_pkg::DATA_W-1:0]  value;
    logic [ctli_pkg::COL_W-1:0]          column;
    logic                                last;

    modport source (output valid, value, column, last, input ready);
    modport sink (input valid, value, column, last, output ready);
endinterface

// ----- hdl/ctli_ram.sv -----
// generic ram: one write port, two registered read ports
// no dependencies

module ctli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/ctli_front.sv -----
// front end: accepts items, clamps and scales queries, forms table commands
// depends on ctli_pkg and ctli_in_if

module ctli_front #(
    parameter int STORE_WORDS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctli_in_if.sink        i_in,
    input  ctli_pkg::t_geom i_geom,
    output logic           o_cmd_valid,
    output ctli_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);
    import ctli_pkg::*;

    logic                 r_s1_valid;
    t_action              r_s1_action;
    logic                 r_s1_addr_ok;
    logic [INDEX_W-1:0]   r_s1_index;
    logic [DATA_W-1:0]    r_s1_value;
    logic [ALPHA_W-1:0]   r_s1_ts;

    logic                 r_s2_valid;
    t_action              r_s2_action;
    logic                 r_s2_addr_ok;
    logic [INDEX_W-1:0]   r_s2_index;
    logic [DATA_W-1:0]    r_s2_value;
    logic [POS_W-1:0]     r_s2_pos;

    logic                 s1_free;
    logic                 s2_free;
    logic                 addr_ok;
    logic [ALPHA_W-1:0]   ts_clamped;
    logic [CFG_W-1:0]     grid_m1;
    logic [CFG_W-1:0]     grid_m2;
    logic [POS_W-FRAC_W-1:0] lower_raw;
    logic [CFG_W-1:0]     lower;
    logic [POS_W-1:0]     alpha_full;
    logic [2*CFG_W-1:0]   base;

    assign addr_ok = int'({20'd0, i_in.table_index}) < STORE_WORDS;

    always_comb begin
        if (i_in.timestep[TS_W-1]) begin
            ts_clamped = '0;
        end else if (i_in.timestep[TS_W-2:0] > ONE_Q16) begin
            ts_clamped = ONE_Q16;
        end else begin
            ts_clamped = i_in.timestep[ALPHA_W-1:0];
        end
    end

    assign grid_m1 = i_geom.grid - 7'd1;
    assign grid_m2 = i_geom.grid - 7'd2;

    assign o_cmd_valid = r_s2_valid && ((r_s2_action == ACT_QUERY) || r_s2_addr_ok);
    assign s2_free     = !r_s2_valid || !o_cmd_valid || i_cmd_ready;
    assign s1_free     = !r_s1_valid || s2_free;
    assign i_in.ready  = s1_free;

    // lower row capped so that the upper row stays in the table
    always_comb begin
        lower_raw  = r_s2_pos[POS_W-1:FRAC_W];
        lower      = (lower_raw > {1'b0, grid_m2}) ? grid_m2 : lower_raw[CFG_W-1:0];
        alpha_full = r_s2_pos - {1'b0, lower, {FRAC_W{1'b0}}};
        base       = {7'd0, lower} * {7'd0, i_geom.embed};
    end

    always_comb begin
        o_cmd.action = r_s2_action;
        o_cmd.wdata  = r_s2_value;
        if (r_s2_action == ACT_QUERY) begin
            o_cmd.addr_a = ADDR_MAX_W'(base);
            o_cmd.addr_b = ADDR_MAX_W'(base + {7'd0, i_geom.embed});
            o_cmd.alpha  = alpha_full[ALPHA_W-1:0];
        end else begin
            o_cmd.addr_a = ADDR_MAX_W'(r_s2_index);
            o_cmd.addr_b = '0;
            o_cmd.alpha  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_action  <= t_action'(i_in.action);
            r_s1_addr_ok <= addr_ok;
            r_s1_index   <= i_in.table_index;
            r_s1_value   <= i_in.table_value;
            r_s1_ts      <= ts_clamped;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_action  <= r_s1_action;
            r_s2_addr_ok <= r_s1_addr_ok;
            r_s2_index   <= r_s1_index;
            r_s2_value   <= r_s1_value;
            r_s2_pos     <= POS_W'(r_s1_ts) * POS_W'(grid_m1);
        end
    end

endmodule

// ----- hdl/ctli_queue.sv -----
// two-entry command queue between front and back end
// depends on ctli_pkg

module ctli_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  ctli_pkg::t_cmd i_push_data,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output ctli_pkg::t_cmd o_pop_data,
    input  logic           i_pop_ready
);
    import ctli_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// ----- hdl/ctli_back.sv -----
// back end: table writes, column sweep over two rows, interpolation pipeline
// depends on ctli_pkg, ctli_out_if and ctli_ram

module ctli_back #(
    parameter int STORE_WORDS = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctli_pkg::t_geom i_geom,
    input  logic            i_cmd_valid,
    input  ctli_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    ctli_out_if.source      o_out
);
    import ctli_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_addr_a;
    logic [AW-1:0]        r_addr_b;
    logic [ALPHA_W-1:0]   r_alpha;
    logic [COL_W-1:0]     r_col;

    logic                 r_s1_valid;
    logic [COL_W-1:0]     r_s1_col;
    logic                 r_s1_last;
    logic [ALPHA_W-1:0]   r_s1_alpha;

    logic                 r_s2_valid;
    logic signed [DATA_W-1:0] r_s2_a;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic [COL_W-1:0]     r_s2_col;
    logic                 r_s2_last;

    logic                 r_o_valid;
    logic [DATA_W-1:0]    r_o_value;
    logic [COL_W-1:0]     r_o_col;
    logic                 r_o_last;

    logic                 adv;
    logic                 issue;
    logic                 col_last;
    logic                 ram_we;
    logic [DATA_W-1:0]    rdata_a;
    logic [DATA_W-1:0]    rdata_b;
    logic signed [DATA_W:0]   diff;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;

    assign adv         = !r_o_valid || o_out.ready;
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign issue       = (r_state == ST_RUN) && adv;
    assign col_last    = ({1'b0, r_col} == (i_geom.embed - 7'd1));
    assign ram_we      = o_cmd_ready && i_cmd_valid && (i_cmd.action == ACT_WRITE);

    ctli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (AW'(i_cmd.addr_a)),
        .i_wdata   (i_cmd.wdata),
        .i_re      (issue),
        .i_raddr_a (r_addr_a + AW'(r_col)),
        .i_raddr_b (r_addr_b + AW'(r_col)),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // floor division by 2^16 is the arithmetic shift
    always_comb begin
        diff    = $signed({rdata_b[DATA_W-1], rdata_b}) - $signed({rdata_a[DATA_W-1], rdata_a});
        alpha_s = $signed({1'b0, r_s1_alpha});
        prod    = diff * alpha_s;
        sum     = PROD_W'(r_s2_a) + (r_s2_prod >>> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && (i_cmd.action == ACT_QUERY)) begin
                        r_col   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (col_last) begin
                            r_col   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_col <= r_col + 6'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (adv) begin
                r_s1_valid <= issue;
                r_s2_valid <= r_s1_valid;
                r_o_valid  <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid && (i_cmd.action == ACT_QUERY)) begin
            r_addr_a <= AW'(i_cmd.addr_a);
            r_addr_b <= AW'(i_cmd.addr_b);
            r_alpha  <= i_cmd.alpha;
        end
        if (adv) begin
            r_s1_col   <= r_col;
            r_s1_last  <= col_last;
            r_s1_alpha <= r_alpha;
            r_s2_a     <= $signed(rdata_a);
            r_s2_prod  <= prod;
            r_s2_col   <= r_s1_col;
            r_s2_last  <= r_s1_last;
            r_o_value  <= sum[DATA_W-1:0];
            r_o_col    <= r_s2_col;
            r_o_last   <= r_s2_last;
        end
    end

    assign o_out.valid  = r_o_valid;
    assign o_out.value  = r_o_value;
    assign o_out.column = r_o_col;
    assign o_out.last   = r_o_last;

endmodule

// ----- hdl/curve_table_linear_interpolator.sv -----
// A curve table of grid_points rows by embed_dim signed Q16.16 words, written one
// word per write item at address row*embed_dim+column (addresses at or beyond
// GRID_MAX*EMBED_MAX are dropped). A query item carries a signed Q2.16 timestep;
// it is clamped to [0,1] and the block returns embed_dim items, one per column,
// interpolated between the two neighbouring rows, with last set on the final
// one. The front end takes one item per cycle while the two-entry command queue
// has room; a write occupies the back end only to take the command, a query to
// take the command and then to issue one read of both rows from the table
// memory for each column, and the back end takes no new command until the
// last column of a query is issued. Table words must be written before any
// query reads them; the table is not cleared after reset.
// depends on ctli_pkg, ctli_in_if, ctli_out_if, ctli_front, ctli_queue, ctli_back

module curve_table_linear_interpolator #(
    parameter int GRID_MAX  = 64,
    parameter int EMBED_MAX = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ctli_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctli_pkg::CFG_W-1:0]         i_cfg_data,
    ctli_in_if.sink                            i_in,
    ctli_out_if.source                         o_out
);
    import ctli_pkg::*;

    localparam int STORE_WORDS = GRID_MAX * EMBED_MAX;

    logic [CFG_W-1:0] r_grid_points;
    logic [CFG_W-1:0] r_embed_dim;
    t_geom            geom;
    logic             push_valid;
    t_cmd             push_data;
    logic             push_ready;
    logic             pop_valid;
    t_cmd             pop_data;
    logic             pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_points <= GRID_RESET;
            r_embed_dim   <= EMBED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_POINTS: r_grid_points <= i_cfg_data;
                CFG_EMBED_DIM:   r_embed_dim   <= i_cfg_data;
                default:         r_grid_points <= r_grid_points;
            endcase
        end
    end

    always_comb begin
        if (r_grid_points < GRID_MIN) begin
            geom.grid = GRID_MIN;
        end else if (int'({25'd0, r_grid_points}) > GRID_MAX) begin
            geom.grid = CFG_W'(GRID_MAX);
        end else begin
            geom.grid = r_grid_points;
        end
        if (r_embed_dim < EMBED_MIN) begin
            geom.embed = EMBED_MIN;
        end else if (int'({25'd0, r_embed_dim}) > EMBED_MAX) begin
            geom.embed = CFG_W'(EMBED_MAX);
        end else begin
            geom.embed = r_embed_dim;
        end
    end

    ctli_front #(
        .STORE_WORDS (STORE_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_geom      (geom),
        .o_cmd_valid (push_valid),
        .o_cmd       (push_data),
        .i_cmd_ready (push_ready)
    );

    ctli_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    ctli_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_data),
        .o_cmd_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

// ----- hdl/ctli_checker.sv -----
// port-level checks on the interpolator output stream, bound to the top level
// depends on ctli_pkg and curve_table_linear_interpolator

module ctli_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_action,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [ctli_pkg::DATA_W-1:0]       i_out_value,
    input logic [ctli_pkg::COL_W-1:0]        i_out_column,
    input logic                              i_out_last
);
    import ctli_pkg::*;

    logic             r_prev_last;
    logic [COL_W-1:0] r_prev_col;
    logic [3:0]       r_open;
    logic             q_acc;
    logic             o_acc;

    assign q_acc = i_in_valid && i_in_ready && (i_in_action == ACT_QUERY);
    assign o_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
            r_prev_col  <= '0;
            r_open      <= '0;
        end else begin
            if (o_acc) begin
                r_prev_last <= i_out_last;
                r_prev_col  <= i_out_column;
            end
            case ({q_acc, o_acc && i_out_last})
                2'b10:   r_open <= r_open + 4'd1;
                2'b01:   r_open <= r_open - 4'd1;
                default: r_open <= r_open;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_column) && $stable(i_out_last))
        else $error("output item changed while stalled");

    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_acc && r_prev_last |-> i_out_column == '0)
        else $error("query results do not start at column zero");

    a_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_acc && !r_prev_last |-> i_out_column == r_prev_col + 6'd1)
        else $error("column sequence broken within a query");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 4'd0)
        else $error("output item without an open query");

endmodule

bind curve_table_linear_interpolator ctli_checker u_ctli_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_action  (i_in.action),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value),
    .i_out_column (o_out.column),
    .i_out_last   (o_out.last)
);

// ----- test/tb_top.sv -----
// self-checking testbench for the curve table linear interpolator
// predicts every interpolated item from a shadow table and geometry registers
// depends on ctli_pkg, ctli_in_if, ctli_out_if and the block itself
`timescale 1ns / 100ps

module tb_top;
    import ctli_pkg::*;

    localparam int GRID_LIMIT  = 64;
    localparam int EMBED_LIMIT = 64;
    localparam int TABLE_WORDS = GRID_LIMIT * EMBED_LIMIT;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        t_action             action;
        logic [INDEX_W-1:0]  index;
        logic [DATA_W-1:0]   value;
        logic [TS_W-1:0]     timestep;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [COL_W-1:0]  column;
        logic              last;
    } t_word_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    ctli_in_if  in_if ();
    ctli_out_if out_if ();

    curve_table_linear_interpolator #(
        .GRID_MAX  (GRID_LIMIT),
        .EMBED_MAX (EMBED_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [DATA_W-1:0] curve_words [0:TABLE_WORDS-1];
    bit                word_written [0:TABLE_WORDS-1];
    logic [CFG_W-1:0]  grid_reg;
    logic [CFG_W-1:0]  embed_reg;
    t_word_result      pending_words [$];
    int                error_count;
    int                burst_left;
    bit                hold_request;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    initial begin
        #200_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int active_rows();
        int g;
        g = int'(grid_reg);
        if (g < 2) g = 2;
        if (g > GRID_LIMIT) g = GRID_LIMIT;
        return g;
    endfunction

    function automatic int active_cols();
        int e;
        e = int'(embed_reg);
        if (e < 1) e = 1;
        if (e > EMBED_LIMIT) e = EMBED_LIMIT;
        return e;
    endfunction

    // shadow of the block: table update or one expected item per column
    task automatic predict_item(input t_request req);
        int g, e, t, pos, lower, alpha;
        longint lo, hi, prod, word;
        t_word_result res;
        if (req.action == ACT_WRITE) begin
            curve_words[req.index] = req.value;
            word_written[req.index] = 1'b1;
        end else begin
            g = active_rows();
            e = active_cols();
            t = int'($signed(req.timestep));
            if (t < 0) t = 0;
            if (t > 65536) t = 65536;
            pos = t * (g - 1);
            lower = pos >> 16;
            if (lower > g - 2) lower = g - 2;
            alpha = pos - (lower << 16);
            for (int c = 0; c < e; c++) begin
                lo = longint'($signed(curve_words[lower * e + c]));
                hi = longint'($signed(curve_words[(lower + 1) * e + c]));
                prod = longint'(alpha) * (hi - lo);
                word = lo + (prod >>> 16);
                res.value = word[DATA_W-1:0];
                res.column = c[COL_W-1:0];
                res.last = (c == e - 1);
                pending_words.push_back(res);
            end
        end
    endtask

    // offers one item in bursts with random gaps, returns once it is taken
    task automatic send_item(input t_request req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 20));
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.action      <= req.action;
        in_if.table_index <= req.index;
        in_if.table_value <= req.value;
        in_if.timestep    <= req.timestep;
        do @(posedge i_clk); while (!in_if.ready);
        predict_item(req);
    endtask

    task automatic write_word(input logic [INDEX_W-1:0] addr, input logic [DATA_W-1:0] data);
        t_request req;
        req.action = ACT_WRITE;
        req.index = addr;
        req.value = data;
        req.timestep = TS_W'($urandom());
        send_item(req);
    endtask

    task automatic query_at(input logic [TS_W-1:0] ts);
        t_request req;
        req.action = ACT_QUERY;
        req.index = INDEX_W'($urandom());
        req.value = $urandom();
        req.timestep = ts;
        send_item(req);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers, then junk to the unmapped indexes
    task automatic set_geometry(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] e);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     dat [4];
        wait_idle();
        idx = '{CFG_GRID_POINTS, CFG_EMBED_DIM, CFG_UNMAPPED_A, CFG_UNMAPPED_B};
        dat = '{g, e, CFG_W'($urandom()), CFG_W'($urandom())};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= dat[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        grid_reg = g;
        embed_reg = e;
    endtask

    task automatic fill_table();
        int words;
        words = active_rows() * active_cols();
        for (int a = 0; a < words; a++) begin
            if (!word_written[a]) write_word(a[INDEX_W-1:0], $urandom());
        end
    endtask

    task automatic random_item();
        t_request req;
        int words, sel;
        words = active_rows() * active_cols();
        req.index = INDEX_W'($urandom());
        req.value = $urandom();
        req.timestep = TS_W'($urandom());
        if ($urandom_range(0, 9) < 4) begin
            req.action = ACT_WRITE;
            if ($urandom_range(0, 9) < 7) req.index = INDEX_W'($urandom_range(0, words - 1));
            sel = int'($urandom_range(0, 9));
            case (sel)
                0: req.value = 32'h7fff_ffff;
                1: req.value = 32'h8000_0000;
                2: req.value = 32'h0000_0000;
                default: req.value = $urandom();
            endcase
        end else begin
            req.action = ACT_QUERY;
            sel = int'($urandom_range(0, 9));
            case (sel)
                0: req.timestep = TS_W'($urandom());
                1: req.timestep = 18'h10000;
                2: req.timestep = 18'h00000;
                default: req.timestep = TS_W'($urandom_range(0, 65536));
            endcase
        end
        send_item(req);
    endtask

    task automatic test_reset_geometry();
        write_word(12'd0,   32'h8000_0000);
        write_word(12'd64,  32'h7fff_ffff);
        write_word(12'd1,   32'h7fff_ffff);
        write_word(12'd65,  32'h8000_0000);
        write_word(12'd63,  32'h0000_0000);
        write_word(12'd127, 32'hffff_ffff);
        fill_table();
        query_at(18'h00000);
        query_at(18'h00001);
        query_at(18'h08000);
        query_at(18'h0ffff);
        query_at(18'h10000);
        query_at(18'h10001);
        query_at(18'h1ffff);
        query_at(18'h3ffff);
        query_at(18'h20000);
    endtask

    task automatic test_register_limits();
        set_geometry(7'd0, 7'd0);
        query_at(18'h08000);
        query_at(18'h10000);
        set_geometry(7'd127, 7'd127);
        query_at(18'h00000);
        query_at(18'h00400);
        query_at(18'h00001);
        query_at(18'h003ff);
        set_geometry(7'd64, 7'd1);
        query_at(18'h0ffff);
        query_at(18'h10000);
        query_at(18'h00400);
        set_geometry(7'd65, 7'd64);
        query_at(18'h00200);
        set_geometry(7'd1, 7'd65);
        query_at(18'h07fff);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] g, e;
        repeat (3) begin
            e = CFG_W'($urandom_range(1, 4));
            g = CFG_W'($urandom_range(2, (e == 7'd1) ? 64 : 128 / int'(e)));
            set_geometry(g, e);
            fill_table();
            repeat (10) random_item();
        end
    endtask

    // output held off while queries keep coming, so the input stalls
    task automatic test_backpressure();
        set_geometry(7'd8, 7'd16);
        hold_request = 1'b1;
        repeat (12) query_at(TS_W'($urandom_range(0, 65536)));
        wait_idle();
    endtask

    initial begin
        int mode, left, hold, phase;
        out_if.ready = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = int'($urandom_range(0, 3));
                    left = int'($urandom_range(20, 120));
                end
                left--;
                phase++;
                case (mode)
                    2: out_if.ready <= 1'($urandom_range(0, 1));
                    3: out_if.ready <= (phase % 4) == 0;
                    default: out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        t_word_result exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (pending_words.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual value %h column %0d last %b",
                             $time, out_if.value, out_if.column, out_if.last);
                end else begin
                    exp = pending_words.pop_front();
                    if (out_if.value !== exp.value) begin
                        error_count++;
                        $display("%0t: value mismatch, expected %h actual %h", $time,
                                 exp.value, out_if.value);
                    end
                    if (out_if.column !== exp.column) begin
                        error_count++;
                        $display("%0t: column mismatch, expected %0d actual %0d", $time,
                                 exp.column, out_if.column);
                    end
                    if (out_if.last !== exp.last) begin
                        error_count++;
                        $display("%0t: last mismatch, expected %b actual %b", $time,
                                 exp.last, out_if.last);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_GRID_POINTS;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.action      = ACT_WRITE;
        in_if.table_index = '0;
        in_if.table_value = '0;
        in_if.timestep    = '0;
        grid_reg          = GRID_RESET;
        embed_reg         = EMBED_RESET;
        error_count       = 0;
        burst_left        = 0;
        hold_request      = 1'b0;
        for (int a = 0; a < TABLE_WORDS; a++) begin
            curve_words[a] = '0;
            word_written[a] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_register_limits();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
